/* src/bezier_path_generator_top_assert.svh */
// assertion macros for the bezier path generator
`ifndef BEZIER_PATH_GENERATOR_TOP_ASSERT_SVH
`define BEZIER_PATH_GENERATOR_TOP_ASSERT_SVH
// implication checked on every clock edge outside reset
`define BPG_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// next-cycle implication outside reset
`define BPG_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

/* src/bpg_pkg.sv */
// shared types and constants of the bezier path generator
package bpg_pkg;
  localparam int unsigned PosW = 32;
  localparam int unsigned RadW = 31;
  localparam int unsigned CntW = 7;
  localparam int unsigned IdxW = 6;
  localparam int unsigned WideW = 40;

  // one request with its control points, between front and back
  typedef struct packed {
    logic signed [WideW-1:0] p0x;
    logic signed [WideW-1:0] p0y;
    logic signed [WideW-1:0] p0r;
    logic signed [WideW-1:0] p1x;
    logic signed [WideW-1:0] p1y;
    logic signed [WideW-1:0] p1r;
    logic signed [WideW-1:0] p2x;
    logic signed [WideW-1:0] p2y;
    logic signed [WideW-1:0] p2r;
    logic signed [WideW-1:0] p3x;
    logic signed [WideW-1:0] p3y;
    logic signed [WideW-1:0] p3r;
    logic [CntW-1:0]         den;
  } bpg_job_t;

  typedef enum logic [1:0] {
    FE_IDLE,
    FE_MUL,
    FE_PUSH
  } bpg_fe_state_e;

  typedef enum logic [3:0] {
    BE_IDLE,
    BE_TDIV,
    BE_SQ,
    BE_CUBE,
    BE_BX,
    BE_BY,
    BE_BR,
    BE_SUM,
    BE_OUT
  } bpg_be_state_e;
endpackage

/* src/bpg_front.sv */
// front part: accepts a request and forms the control points
module bpg_front #(
  parameter int unsigned MaxSteps = 64,
  parameter int unsigned FracBits = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic signed [bpg_pkg::PosW-1:0] start_x_i,
  input  logic signed [bpg_pkg::PosW-1:0] start_y_i,
  input  logic [bpg_pkg::RadW-1:0]       start_radius_i,
  input  logic signed [bpg_pkg::PosW-1:0] goal_x_i,
  input  logic signed [bpg_pkg::PosW-1:0] goal_y_i,
  input  logic [bpg_pkg::RadW-1:0]       goal_radius_i,
  input  logic [bpg_pkg::CntW-1:0]       step_count_i,
  output logic                           job_valid_o,
  input  logic                           job_ready_i,
  output bpg_pkg::bpg_job_t              job_o
);
  import bpg_pkg::*;

  localparam logic signed [63:0] One  = 64'sd1 <<< FracBits;
  localparam logic signed [63:0] Half = 64'sd1 <<< (FracBits - 1);
  localparam logic signed [63:0] K30  = (64'sd3 * One + 64'sd5) / 64'sd10;
  localparam logic signed [63:0] K33  = (64'sd33 * One + 64'sd50) / 64'sd100;
  localparam logic signed [63:0] K66  = (64'sd66 * One + 64'sd50) / 64'sd100;

  bpg_fe_state_e state_q, state_d;
  logic signed [33:0] dx_q, dy_q, dr_q;
  logic signed [WideW-1:0] sx_q, sy_q, sr_q, gx_q, gy_q, gr_q;
  logic [CntW-1:0] den_q;
  logic signed [63:0] ax_q, ay_q, a33_q, a66_q;
  logic [CntW-1:0] n_sat;

  // clamp the step count into range
  always_comb begin
    if (step_count_i < CntW'(2)) n_sat = CntW'(2);
    else if (step_count_i > CntW'(MaxSteps)) n_sat = CntW'(MaxSteps);
    else n_sat = step_count_i;
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      FE_IDLE: if (in_valid_i) state_d = FE_MUL;
      FE_MUL:  state_d = FE_PUSH;
      FE_PUSH: if (job_ready_i) state_d = FE_IDLE;
      default: state_d = FE_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready_o  = (state_q == FE_IDLE);
    job_valid_o = (state_q == FE_PUSH);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= FE_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // capture the request and differences, then scale them with one multiply per register
  always_ff @(posedge clk_i) begin
    if (state_q == FE_IDLE && in_valid_i) begin
      sx_q  <= WideW'(start_x_i);
      sy_q  <= WideW'(start_y_i);
      sr_q  <= WideW'($signed({1'b0, start_radius_i}));
      gx_q  <= WideW'(goal_x_i);
      gy_q  <= WideW'(goal_y_i);
      gr_q  <= WideW'($signed({1'b0, goal_radius_i}));
      dx_q  <= 34'(goal_x_i) - 34'(start_x_i);
      dy_q  <= 34'(goal_y_i) - 34'(start_y_i);
      dr_q  <= $signed({3'b0, goal_radius_i}) - $signed({3'b0, start_radius_i});
      den_q <= n_sat - CntW'(1);
    end
    if (state_q == FE_MUL) begin
      ax_q  <= (64'(dx_q) * K30 + Half) >>> FracBits;
      ay_q  <= (64'(dy_q) * K30 + Half) >>> FracBits;
      a33_q <= (64'(dr_q) * K33 + Half) >>> FracBits;
      a66_q <= (64'(dr_q) * K66 + Half) >>> FracBits;
    end
  end

  // control points
  always_comb begin
    job_o.p0x = sx_q;
    job_o.p0y = sy_q;
    job_o.p0r = sr_q;
    job_o.p3x = gx_q;
    job_o.p3y = gy_q;
    job_o.p3r = gr_q;
    job_o.p1x = sx_q + WideW'(ax_q) - WideW'(ay_q);
    job_o.p1y = sy_q + WideW'(ay_q) + WideW'(ax_q);
    job_o.p2x = gx_q - WideW'(ax_q) - WideW'(ay_q);
    job_o.p2y = gy_q - WideW'(ay_q) + WideW'(ax_q);
    job_o.p1r = sr_q + WideW'(a33_q);
    job_o.p2r = sr_q + WideW'(a66_q);
    job_o.den = den_q;
  end
endmodule

/* src/bpg_queue.sv */
// two-entry queue between front and back
module bpg_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              wr_valid_i,
  output logic              wr_ready_o,
  input  bpg_pkg::bpg_job_t wr_data_i,
  output logic              rd_valid_o,
  input  logic              rd_ready_i,
  output bpg_pkg::bpg_job_t rd_data_o
);
  import bpg_pkg::*;

  bpg_job_t mem_q [2];
  logic wp_q, rp_q;
  logic [1:0] cnt_q;
  logic wr_en, rd_en;

  assign wr_ready_o = (cnt_q != 2'd2);
  assign rd_valid_o = (cnt_q != 2'd0);
  assign wr_en = wr_valid_i && wr_ready_o;
  assign rd_en = rd_valid_o && rd_ready_i;
  assign rd_data_o = mem_q[rp_q];

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (wr_en) wp_q <= ~wp_q;
      if (rd_en) rp_q <= ~rp_q;
      cnt_q <= cnt_q + 2'(wr_en) - 2'(rd_en);
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (wr_en) mem_q[wp_q] <= wr_data_i;
  end
endmodule

/* src/bpg_back.sv */
// back part: samples the curve node by node
module bpg_back #(
  parameter int unsigned FracBits = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            job_valid_i,
  output logic                            job_ready_o,
  input  bpg_pkg::bpg_job_t               job_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic signed [bpg_pkg::PosW-1:0] node_x_o,
  output logic signed [bpg_pkg::PosW-1:0] node_y_o,
  output logic [bpg_pkg::RadW-1:0]        node_radius_o,
  output logic [bpg_pkg::IdxW-1:0]        node_index_o,
  output logic                            last_node_o
);
  import bpg_pkg::*;

  localparam int unsigned TW = FracBits + 1;
  localparam int unsigned NumW = FracBits + CntW + 1;
  localparam int unsigned MW = FracBits + 2;
  localparam int unsigned PW = 2 * MW;
  localparam int unsigned BW = MW + 1;
  localparam int unsigned MacW = WideW + BW;
  localparam logic signed [63:0] One  = 64'sd1 <<< FracBits;
  localparam logic signed [63:0] Half = 64'sd1 <<< (FracBits - 1);
  localparam logic signed [95:0] HalfW = 96'sd1 <<< (FracBits - 1);

  bpg_be_state_e state_q, state_d;
  bpg_job_t job_q;
  logic [CntW-1:0] idx_q;
  logic [NumW-1:0] rem_q;
  logic [TW-1:0] t_q;
  logic [4:0] bit_q;
  logic signed [MW-1:0] uu_q, tt_q, b0_q, b3_q;
  logic signed [BW-1:0] b1_q, b2_q;
  logic signed [95:0] acc_q, sx_q, sy_q, sr_q;
  logic [1:0] term_q;
  logic signed [MW-1:0] t_s, u_s;
  logic signed [PW-1:0] sq_u, sq_t, cb_uuu, cb_uut, cb_utt, cb_ttt;
  logic [NumW-1:0] rem_sh, rem_in, den_w, num_w, num_nxt;
  logic signed [BW-1:0] bsel;
  logic signed [WideW-1:0] psel;
  logic signed [MacW-1:0] prod;
  logic signed [95:0] rx, ry, rr;
  logic last_idx;

  assign t_s = $signed({1'b0, t_q});
  assign u_s = MW'(One) - t_s;
  assign den_w = NumW'(job_q.den);
  assign rem_sh = {rem_q[NumW-2:0], 1'b0};
  assign last_idx = (idx_q == job_q.den);

  // dividend i<<F + den/2 for this node and the next one
  assign num_w = (NumW'(idx_q) << FracBits) + NumW'(job_q.den >> 1);
  assign num_nxt = (NumW'(idx_q + CntW'(1)) << FracBits) + NumW'(job_q.den >> 1);
  assign rem_in = rem_sh | NumW'(num_w[bit_q]);

  // narrow products for the weights
  assign sq_u = u_s * u_s;
  assign sq_t = t_s * t_s;
  assign cb_uuu = uu_q * u_s;
  assign cb_uut = uu_q * t_s;
  assign cb_utt = u_s * tt_q;
  assign cb_ttt = tt_q * t_s;

  // shared multiply-accumulate product
  assign prod = bsel * psel;

  // rounded sums
  assign rx = (sx_q + HalfW) >>> FracBits;
  assign ry = (sy_q + HalfW) >>> FracBits;
  assign rr = (sr_q + HalfW) >>> FracBits;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      BE_IDLE: if (job_valid_i) state_d = BE_TDIV;
      BE_TDIV: if (bit_q == 5'd0) state_d = BE_SQ;
      BE_SQ:   state_d = BE_CUBE;
      BE_CUBE: state_d = BE_BX;
      BE_BX:   if (term_q == 2'd3) state_d = BE_BY;
      BE_BY:   if (term_q == 2'd3) state_d = BE_BR;
      BE_BR:   if (term_q == 2'd3) state_d = BE_SUM;
      BE_SUM:  state_d = BE_OUT;
      BE_OUT:  if (out_ready_i) state_d = last_idx ? BE_IDLE : BE_TDIV;
      default: state_d = BE_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    job_ready_o = (state_q == BE_IDLE);
    out_valid_o = (state_q == BE_OUT);
  end

  // weight and point selection for the shared multiplier
  always_comb begin
    case (term_q)
      2'd0: bsel = BW'(b0_q);
      2'd1: bsel = b1_q;
      2'd2: bsel = b2_q;
      default: bsel = BW'(b3_q);
    endcase
    case (state_q)
      BE_BX: begin
        case (term_q)
          2'd0: psel = job_q.p0x;
          2'd1: psel = job_q.p1x;
          2'd2: psel = job_q.p2x;
          default: psel = job_q.p3x;
        endcase
      end
      BE_BY: begin
        case (term_q)
          2'd0: psel = job_q.p0y;
          2'd1: psel = job_q.p1y;
          2'd2: psel = job_q.p2y;
          default: psel = job_q.p3y;
        endcase
      end
      default: begin
        case (term_q)
          2'd0: psel = job_q.p0r;
          2'd1: psel = job_q.p1r;
          2'd2: psel = job_q.p2r;
          default: psel = job_q.p3r;
        endcase
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BE_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    case (state_q)
      BE_IDLE: begin
        if (job_valid_i) begin
          job_q <= job_i;
          idx_q <= '0;
          rem_q <= '0;
          t_q   <= '0;
          bit_q <= 5'(TW - 1);
        end
      end
      BE_TDIV: begin
        // restoring division by den, one quotient bit a cycle; the remainder
        // starts with the dividend bits above the quotient
        if (rem_in >= den_w) begin
          rem_q <= rem_in - den_w;
          t_q[bit_q[$clog2(TW)-1:0]] <= 1'b1;
        end else begin
          rem_q <= rem_in;
        end
        bit_q <= bit_q - 5'd1;
        if (bit_q == 5'd0) term_q <= 2'd0;
      end
      BE_SQ: begin
        uu_q <= MW'((sq_u + PW'(Half)) >>> FracBits);
        tt_q <= MW'((sq_t + PW'(Half)) >>> FracBits);
      end
      BE_CUBE: begin
        b0_q <= MW'((cb_uuu + PW'(Half)) >>> FracBits);
        b1_q <= BW'(3) * BW'((cb_uut + PW'(Half)) >>> FracBits);
        b2_q <= BW'(3) * BW'((cb_utt + PW'(Half)) >>> FracBits);
        b3_q <= MW'((cb_ttt + PW'(Half)) >>> FracBits);
        acc_q <= '0;
        term_q <= 2'd0;
      end
      BE_BX, BE_BY, BE_BR: begin
        if (term_q == 2'd3) begin
          acc_q <= '0;
          if (state_q == BE_BX) sx_q <= acc_q + 96'(prod);
          if (state_q == BE_BY) sy_q <= acc_q + 96'(prod);
          if (state_q == BE_BR) sr_q <= acc_q + 96'(prod);
        end else begin
          acc_q <= acc_q + 96'(prod);
        end
        term_q <= term_q + 2'd1;
      end
      BE_SUM: begin
        if (rx > 96'sh7FFFFFFF) node_x_o <= 32'sh7FFFFFFF;
        else if (rx < -96'sh80000000) node_x_o <= 32'sh80000000;
        else node_x_o <= rx[31:0];
        if (ry > 96'sh7FFFFFFF) node_y_o <= 32'sh7FFFFFFF;
        else if (ry < -96'sh80000000) node_y_o <= 32'sh80000000;
        else node_y_o <= ry[31:0];
        if (rr > 96'sh7FFFFFFF) node_radius_o <= 31'h7FFFFFFF;
        else if (rr < 96'sd0) node_radius_o <= '0;
        else node_radius_o <= rr[30:0];
        node_index_o <= idx_q[IdxW-1:0];
        last_node_o <= last_idx;
      end
      BE_OUT: begin
        if (out_ready_i && !last_idx) begin
          idx_q <= idx_q + CntW'(1);
          rem_q <= num_nxt >> TW;
          t_q   <= '0;
          bit_q <= 5'(TW - 1);
        end
      end
      default: ;
    endcase
  end
endmodule

/* src/bezier_path_generator_top.sv */
// top level of the bezier path generator
// Cubic Bezier path generator.
// Input channel in_valid_i/in_ready_o carries one request beat: start and
// goal node (x, y Q16.16, radius UQ15.16), step count clamped to 2..MAX_STEPS.
// Output channel out_valid_o/out_ready_i returns one beat per curve node,
// in index order, with last_node_o set on the goal node.
// The front forms the control points and pushes them into a two-entry
// queue, so it takes the next request while the back still works.
// Per node the back divides for t, one quotient bit a cycle over FRAC_BITS+1
// quotient bits, forms the weights in the square and cube states, runs the
// x, y and radius sums over the four terms of the shared multiply-accumulate,
// rounds and clamps the sums, and then hands out the beat.
// Reset clears the control state and empties the queue; no clearing pass.
// When the receiver stalls, the node is held at the ports and the back
// waits; the front fills the queue and then drops in_ready_o.
module bezier_path_generator_top #(
  parameter int unsigned MAX_STEPS = 64,
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic signed [bpg_pkg::PosW-1:0] start_x_i,
  input  logic signed [bpg_pkg::PosW-1:0] start_y_i,
  input  logic [bpg_pkg::RadW-1:0]        start_radius_i,
  input  logic signed [bpg_pkg::PosW-1:0] goal_x_i,
  input  logic signed [bpg_pkg::PosW-1:0] goal_y_i,
  input  logic [bpg_pkg::RadW-1:0]        goal_radius_i,
  input  logic [bpg_pkg::CntW-1:0]        step_count_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic signed [bpg_pkg::PosW-1:0] node_x_o,
  output logic signed [bpg_pkg::PosW-1:0] node_y_o,
  output logic [bpg_pkg::RadW-1:0]        node_radius_o,
  output logic [bpg_pkg::IdxW-1:0]        node_index_o,
  output logic                            last_node_o
);
  import bpg_pkg::*;

  bpg_job_t fe_job, be_job;
  logic fe_valid, fe_ready, be_valid, be_ready;

  // front: clamp the step count, build control points
  bpg_front #(.MaxSteps(MAX_STEPS), .FracBits(FRAC_BITS)) u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o,
    .start_x_i, .start_y_i, .start_radius_i,
    .goal_x_i, .goal_y_i, .goal_radius_i, .step_count_i,
    .job_valid_o(fe_valid), .job_ready_i(fe_ready), .job_o(fe_job)
  );

  // queue between front and back
  bpg_queue u_queue (
    .clk_i, .rst_ni,
    .wr_valid_i(fe_valid), .wr_ready_o(fe_ready), .wr_data_i(fe_job),
    .rd_valid_o(be_valid), .rd_ready_i(be_ready), .rd_data_o(be_job)
  );

  // back: evaluate curve nodes
  bpg_back #(.FracBits(FRAC_BITS)) u_back (
    .clk_i, .rst_ni,
    .job_valid_i(be_valid), .job_ready_o(be_ready), .job_i(be_job),
    .out_valid_o, .out_ready_i,
    .node_x_o, .node_y_o, .node_radius_o, .node_index_o, .last_node_o
  );
endmodule

/* src/bpg_checker.sv */
// port checker for the bezier path generator
`include "bezier_path_generator_top_assert.svh"
module bpg_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            out_valid_o,
  input logic                            out_ready_i,
  input logic [bpg_pkg::IdxW-1:0]        node_index_o,
  input logic                            last_node_o,
  input logic [bpg_pkg::PosW-1:0]        node_x_o
);
  // a stalled node beat holds
  `BPG_ASSERT_NEXT(a_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o && $stable(node_x_o))
  // node after a non-last beat has the next index
  `BPG_ASSERT_NEXT(a_seq, clk_i, rst_ni, out_valid_o && out_ready_i && !last_node_o, !out_valid_o || node_index_o == $past(node_index_o) + 6'd1)
  // a run never ends at index zero
  `BPG_ASSERT_IMP(a_last, clk_i, rst_ni, out_valid_o && last_node_o, node_index_o != 6'd0)
endmodule

bind bezier_path_generator_top bpg_checker u_bpg_checker (
  .clk_i, .rst_ni, .out_valid_o, .out_ready_i, .node_index_o, .last_node_o, .node_x_o
);
